FILE: hdl/iirfs_pkg.sv
// Shared types and constants of the saturating biquad filter.
package iirfs_pkg;

    localparam int COEF_W     = 32;  // Q16.16 coefficient width
    localparam int LIMIT_W    = 15;  // clamp magnitude width
    localparam int CFG_ADDR_W = 4;   // config index width
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_NUM0  = 4'd0,
        REG_NUM1  = 4'd1,
        REG_NUM2  = 4'd2,
        REG_DEN1  = 4'd3,
        REG_DEN2  = 4'd4,
        REG_RECIP = 4'd5,
        REG_GAIN  = 4'd6,
        REG_LIMIT = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] num0;
        logic signed [COEF_W-1:0] num1;
        logic signed [COEF_W-1:0] num2;
        logic signed [COEF_W-1:0] den1;
        logic signed [COEF_W-1:0] den2;
        logic signed [COEF_W-1:0] recip;
        logic signed [COEF_W-1:0] gain;
        logic [LIMIT_W-1:0]       limit;
    } t_coefs;

    // What the registered product is used for in the following cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_NUM,    // add to numerator sum
        OP_FB,     // add to feedback sum
        OP_MQ_LO,  // low chunk of a Q16.16 scaling
        OP_MQ_HI   // high chunk, finishes the scaling
    } t_mul_op;

    typedef enum logic [2:0] {
        COEF_B0,
        COEF_B1,
        COEF_B2,
        COEF_A1,
        COEF_A2,
        COEF_GAIN,
        COEF_RECIP
    } t_coef_sel;

    typedef enum logic [2:0] {
        OPND_X0,
        OPND_X1,
        OPND_X2,
        OPND_Y1,
        OPND_Y2,
        OPND_MQ_LO,
        OPND_MQ_HI
    } t_opnd_sel;

    // Controller to datapath command word
    typedef struct packed {
        logic      capture;   // take new sample, clear sums
        t_mul_op   mul_op;
        t_coef_sel coef;
        t_opnd_sel opnd;
        logic      load_mag;  // latch magnitude of scaling operand
        logic      mag_acc;   // 1: from accumulator, 0: from numerator sum
        logic      fbsub;     // acc -= feedback sum
        logic      round;     // round accumulator to integer sample
        logic      write;     // clamp, load output, shift histories
    } t_cmd;

endpackage

FILE: hdl/iir_filter_with_saturation.sv
// Top level of the direct form I biquad filter with output clamping.
//
// Direct form I IIR filter of order one or two (ORDER) on signed samples of
// SAMPLE_WIDTH bits. For each sample transfer it computes
//   y = recip * (gain * (b0 x[n] + b1 x[n-1] + b2 x[n-2]) - a1 y[n-1] - a2 y[n-2])
// with Q16.16 coefficients, intermediate Q.16 sums saturating at +-(2^62 - 1),
// Q16.16 scalings rounded half away from zero, and a final round to an
// integer sample. The result is clamped to +-saturation_limit when that
// register is nonzero and always to the sample range; o_clipped flags any
// clamp. The clamped result is what feeds back. Configuration registers
// (index on i_cfg_addr): 0..2 b0..b2, 3..4 a1..a2, 5 reciprocal of a0,
// 6 forward gain, 7 saturation limit; other indexes are ignored. Write them
// only while the filter is idle. The single 32x32 multiplier takes the
// coefficient products (five at ORDER 2, three at ORDER 1) and two two-chunk
// scalings in turn, then the rounding and clamp steps follow. One sample is
// in flight at a time: o_ready stays low from an accepted sample until its
// result is loaded into the held output register, which waits until any
// earlier result is taken on i_ready; reset clears both sample histories at once.
module iir_filter_with_saturation import iirfs_pkg::*; #(
    parameter int ORDER        = 2,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample input channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_clipped,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0]          i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data
);

    t_coefs coefs;
    t_cmd   cmd;

    // register bank; always ready, a transfer writes one register
    iirfs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (coefs)
    );

    // sequencer: owns both handshakes, issues one command word per cycle
    iirfs_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // arithmetic, histories and output register
    iirfs_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_coefs   (coefs),
        .i_sample  (i_sample_in),
        .o_sample  (o_sample_out),
        .o_clipped (o_clipped)
    );

endmodule

FILE: hdl/iirfs_cfg.sv
// Configuration register bank of the saturating biquad filter.
module iirfs_cfg import iirfs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_coefs                o_coefs
);

    t_coefs r_coefs;

    assign o_cfg_ready = 1'b1;
    assign o_coefs     = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.num0  <= '0;
            r_coefs.num1  <= '0;
            r_coefs.num2  <= '0;
            r_coefs.den1  <= '0;
            r_coefs.den2  <= '0;
            r_coefs.recip <= 32'sd65536;  // 1.0
            r_coefs.gain  <= 32'sd65536;  // 1.0
            r_coefs.limit <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_addr))
                REG_NUM0:  r_coefs.num0  <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_NUM1:  r_coefs.num1  <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_NUM2:  r_coefs.num2  <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_DEN1:  r_coefs.den1  <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_DEN2:  r_coefs.den2  <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_RECIP: r_coefs.recip <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_GAIN:  r_coefs.gain  <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_LIMIT: r_coefs.limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                    // indexes past the list are dropped
                end
            endcase
        end
    end

endmodule

FILE: hdl/iirfs_dp.sv
// Datapath: shared 32x32 multiplier, saturating sums, scaling, round and clamp.
module iirfs_dp import iirfs_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    input  t_coefs                         i_coefs,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample,
    output logic                           o_clipped
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int YW = 48;  // rounded result fits in 48 bits signed
    localparam logic [63:0]        ACC_MAX   = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MAX_S = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [YW-1:0] SMAX = YW'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic signed [YW-1:0] SMIN = -SMAX - YW'(1);

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (s > ACC_MAX_S) begin
            return ACC_MAX_S;
        end else if (s < -ACC_MAX_S) begin
            return -ACC_MAX_S;
        end
        return s;
    endfunction

    // history and working registers
    logic signed [SW-1:0] r_x0;
    logic signed [SW-1:0] r_xh [2];
    logic signed [SW-1:0] r_yh [2];
    logic signed [63:0]   r_num, r_fb, r_acc;
    logic [61:0]          r_opmag;
    logic                 r_opneg;
    logic [63:0]          r_prod;
    logic                 r_prod_neg;
    t_mul_op              r_prod_op;
    logic [47:0]          r_rt;
    logic signed [YW-1:0] r_y;
    logic signed [SW-1:0] r_out_sample;
    logic                 r_out_clip;

    logic signed [COEF_W-1:0] coef;
    logic signed [32:0]       coef_ext;
    logic [31:0]              coef_mag;
    logic signed [SW-1:0]     samp;
    logic signed [32:0]       samp_ext;
    logic [31:0]              samp_mag;
    logic [31:0]              opnd_mag;
    logic                     opnd_neg;
    logic [63:0]              pmag;
    logic signed [63:0]       psig;
    logic [62:0]              hi_sum;
    logic [63:0]              hi_mag;
    logic signed [63:0]       hi_sig;
    logic [47:0]              n_rt;
    logic signed [63:0]       mag_src;
    logic signed [63:0]       mag_abs;
    logic [63:0]              acc_abs;
    logic [63:0]              ym;
    logic signed [63:0]       y_full;
    logic signed [YW-1:0]     lim;
    logic signed [YW-1:0]     y_c;
    logic                     clip;

    assign o_sample  = r_out_sample;
    assign o_clipped = r_out_clip;

    // multiplier operand selection
    always_comb begin
        case (i_cmd.coef)
            COEF_B0:    coef = i_coefs.num0;
            COEF_B1:    coef = i_coefs.num1;
            COEF_B2:    coef = i_coefs.num2;
            COEF_A1:    coef = i_coefs.den1;
            COEF_A2:    coef = i_coefs.den2;
            COEF_GAIN:  coef = i_coefs.gain;
            COEF_RECIP: coef = i_coefs.recip;
            default:    coef = i_coefs.gain;
        endcase
        coef_ext = 33'(coef);
        coef_mag = coef[COEF_W-1] ? 32'(-coef_ext) : 32'(coef_ext);

        case (i_cmd.opnd)
            OPND_X1: samp = r_xh[0];
            OPND_X2: samp = r_xh[1];
            OPND_Y1: samp = r_yh[0];
            OPND_Y2: samp = r_yh[1];
            default: samp = r_x0;
        endcase
        samp_ext = 33'(samp);
        samp_mag = samp[SW-1] ? 32'(-samp_ext) : 32'(samp_ext);

        case (i_cmd.opnd)
            OPND_MQ_LO: begin
                opnd_mag = r_opmag[31:0];
                opnd_neg = r_opneg;
            end
            OPND_MQ_HI: begin
                opnd_mag = {2'b00, r_opmag[61:32]};
                opnd_neg = r_opneg;
            end
            default: begin
                opnd_mag = samp_mag;
                opnd_neg = samp[SW-1];
            end
        endcase
    end

    // post-multiply arithmetic
    always_comb begin
        pmag = (r_prod > ACC_MAX) ? ACC_MAX : r_prod;
        psig = r_prod_neg ? -$signed(pmag) : $signed(pmag);

        // (P_hi * 2^32 + P_lo + 2^15) >> 16 == P_hi * 2^16 + r_rt
        n_rt   = 48'((r_prod + 64'h8000) >> 16);
        hi_sum = {1'b0, r_prod[45:0], 16'h0000} + 63'(r_rt);
        hi_mag = ((r_prod[63:46] != '0) || (hi_sum > 63'(ACC_MAX))) ? ACC_MAX
                                                                   : 64'(hi_sum);
        hi_sig = r_prod_neg ? -$signed(hi_mag) : $signed(hi_mag);

        mag_src = i_cmd.mag_acc ? r_acc : r_num;
        mag_abs = mag_src[63] ? -mag_src : mag_src;

        // round half away from zero
        acc_abs = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
        ym      = (acc_abs + 64'h8000) >> 16;
        y_full  = r_acc[63] ? -$signed(ym) : $signed(ym);

        // limit clamp, then sample range clamp
        lim  = $signed({{(YW - LIMIT_W){1'b0}}, i_coefs.limit});
        y_c  = r_y;
        clip = 1'b0;
        if (i_coefs.limit != '0) begin
            if (y_c > lim) begin
                y_c  = lim;
                clip = 1'b1;
            end
            if (y_c < -lim) begin
                y_c  = -lim;
                clip = 1'b1;
            end
        end
        if (y_c > SMAX) begin
            y_c  = SMAX;
            clip = 1'b1;
        end
        if (y_c < SMIN) begin
            y_c  = SMIN;
            clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_op <= OP_NONE;
            r_xh[0]   <= '0;
            r_xh[1]   <= '0;
            r_yh[0]   <= '0;
            r_yh[1]   <= '0;
        end else begin
            r_prod_op <= i_cmd.mul_op;
            if (i_cmd.write) begin
                r_xh[0] <= r_x0;
                r_xh[1] <= r_xh[0];
                r_yh[0] <= y_c[SW-1:0];
                r_yh[1] <= r_yh[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= coef_mag * opnd_mag;
        r_prod_neg <= coef[COEF_W-1] ^ opnd_neg;

        if (i_cmd.capture) begin
            r_x0  <= i_sample;
            r_num <= '0;
            r_fb  <= '0;
        end else begin
            case (r_prod_op)
                OP_NUM:   r_num <= sat_add(r_num, psig);
                OP_FB:    r_fb  <= sat_add(r_fb, psig);
                OP_MQ_LO: r_rt  <= n_rt;
                OP_MQ_HI: r_acc <= hi_sig;
                default: begin
                end
            endcase
        end

        if (i_cmd.load_mag) begin
            r_opmag <= mag_abs[61:0];
            r_opneg <= mag_src[63];
        end
        if (i_cmd.fbsub) begin
            r_acc <= sat_add(r_acc, -r_fb);
        end
        if (i_cmd.round) begin
            r_y <= y_full[YW-1:0];
        end
        if (i_cmd.write) begin
            r_out_sample <= y_c[SW-1:0];
            r_out_clip   <= clip;
        end
    end

endmodule

FILE: hdl/iirfs_ctrl.sv
// Sequencer: steps one sample through the shared multiplier and output handshake.
module iirfs_ctrl import iirfs_pkg::*; #(
    parameter int ORDER = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MAC0,
        ST_MAC1,
        ST_MAC2,
        ST_MAC3,
        ST_MAC4,
        ST_GMAG,
        ST_GLO,
        ST_GHI,
        ST_GWAIT,
        ST_FBSUB,
        ST_RMAG,
        ST_RLO,
        ST_RHI,
        ST_RWAIT,
        ST_ROUND,
        ST_WRITE
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   out_free;

    assign o_ready  = r_in_ready;
    assign o_valid  = r_out_valid;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_op  = OP_NONE;
        o_cmd.coef    = COEF_B0;
        o_cmd.opnd    = OPND_X0;
        o_cmd.capture = r_in_ready && i_valid;
        case (r_state)
            ST_MAC0: begin
                o_cmd.mul_op = OP_NUM;
                o_cmd.coef   = COEF_B0;
                o_cmd.opnd   = OPND_X0;
            end
            ST_MAC1: begin
                o_cmd.mul_op = OP_NUM;
                o_cmd.coef   = COEF_B1;
                o_cmd.opnd   = OPND_X1;
            end
            ST_MAC2: begin
                o_cmd.mul_op = OP_NUM;
                o_cmd.coef   = COEF_B2;
                o_cmd.opnd   = OPND_X2;
            end
            ST_MAC3: begin
                o_cmd.mul_op = OP_FB;
                o_cmd.coef   = COEF_A1;
                o_cmd.opnd   = OPND_Y1;
            end
            ST_MAC4: begin
                o_cmd.mul_op = OP_FB;
                o_cmd.coef   = COEF_A2;
                o_cmd.opnd   = OPND_Y2;
            end
            ST_GMAG: begin
                o_cmd.load_mag = 1'b1;
                o_cmd.mag_acc  = 1'b0;
            end
            ST_GLO: begin
                o_cmd.mul_op = OP_MQ_LO;
                o_cmd.coef   = COEF_GAIN;
                o_cmd.opnd   = OPND_MQ_LO;
            end
            ST_GHI: begin
                o_cmd.mul_op = OP_MQ_HI;
                o_cmd.coef   = COEF_GAIN;
                o_cmd.opnd   = OPND_MQ_HI;
            end
            ST_FBSUB: o_cmd.fbsub = 1'b1;
            ST_RMAG: begin
                o_cmd.load_mag = 1'b1;
                o_cmd.mag_acc  = 1'b1;
            end
            ST_RLO: begin
                o_cmd.mul_op = OP_MQ_LO;
                o_cmd.coef   = COEF_RECIP;
                o_cmd.opnd   = OPND_MQ_LO;
            end
            ST_RHI: begin
                o_cmd.mul_op = OP_MQ_HI;
                o_cmd.coef   = COEF_RECIP;
                o_cmd.opnd   = OPND_MQ_HI;
            end
            ST_ROUND: o_cmd.round = 1'b1;
            ST_WRITE: o_cmd.write = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.write) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_in_ready <= 1'b0;
                        r_state    <= ST_MAC0;
                    end
                end
                ST_MAC0:  r_state <= ST_MAC1;
                ST_MAC1:  r_state <= (ORDER >= 2) ? ST_MAC2 : ST_MAC3;
                ST_MAC2:  r_state <= ST_MAC3;
                ST_MAC3:  r_state <= (ORDER >= 2) ? ST_MAC4 : ST_GMAG;
                ST_MAC4:  r_state <= ST_GMAG;
                ST_GMAG:  r_state <= ST_GLO;
                ST_GLO:   r_state <= ST_GHI;
                ST_GHI:   r_state <= ST_GWAIT;
                ST_GWAIT: r_state <= ST_FBSUB;
                ST_FBSUB: r_state <= ST_RMAG;
                ST_RMAG:  r_state <= ST_RLO;
                ST_RLO:   r_state <= ST_RHI;
                ST_RHI:   r_state <= ST_RWAIT;
                ST_RWAIT: r_state <= ST_ROUND;
                ST_ROUND: r_state <= ST_WRITE;
                ST_WRITE: begin
                    if (out_free) begin
                        r_in_ready <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_in_ready <= 1'b1;
                    r_state    <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
